@@ rtl/bit_unpack_dequantizer_defines.svh @@
// assertion macros used by the checker file bud_checker.sv
`ifndef BIT_UNPACK_DEQUANTIZER_DEFINES_SVH
`define BIT_UNPACK_DEQUANTIZER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define BUD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define BUD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bud_pkg.sv @@
package bud_pkg;

    // fixed field widths
    localparam int WORD_BITS   = 16;
    localparam int CODE_W      = 16;
    localparam int BPV_W       = 5;
    localparam int ELEM_W      = 24;
    localparam int MIN_W       = 32;
    localparam int BUCKET_W    = 24;
    localparam int VALUE_W     = 48;
    localparam int PROD_W      = CODE_W + BUCKET_W;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int BUF_W       = 31;
    localparam int CNT_W       = 5;
    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS);
    localparam int STEP_W      = 1;

    // default for the code counter width
    localparam int COUNT_WIDTH_DEF = 24;

    // register reset values
    localparam logic [BPV_W-1:0]    BPV_RST    = BPV_W'(8);
    localparam logic [ELEM_W-1:0]   ELEM_RST   = '0;
    localparam logic [MIN_W-1:0]    MIN_RST    = '0;
    localparam logic [BUCKET_W-1:0] BUCKET_RST = BUCKET_W'(65536);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BITS_PER_VALUE = 2'd0,
        REG_ELEMENT_COUNT  = 2'd1,
        REG_MIN_VALUE      = 2'd2,
        REG_BUCKET_SIZE    = 2'd3
    } cfg_reg_t;

    // microprogram step addresses
    typedef enum logic [STEP_W-1:0] {
        STEP_WAIT = 1'b0,
        STEP_EMIT = 1'b1
    } step_t;

    // jump conditions
    typedef enum logic {
        JC_UNLESS_LOAD = 1'b0,
        JC_WHILE_MORE  = 1'b1
    } jump_cond_t;

    // one control word
    typedef struct packed {
        logic       take_req;
        logic       emit;
        jump_cond_t cond;
        step_t      target;
    } uword_t;

    // code handed from the unpacker to the dequantiser pipeline
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic              last;
        logic              done;
    } issue_t;

    // control store: wait for a word, then emit codes through its last code
    function automatic uword_t ucode_rom(step_t step);
        uword_t uw;
        unique case (step)
            STEP_WAIT: uw = '{take_req: 1'b1, emit: 1'b0,
                              cond: JC_UNLESS_LOAD, target: STEP_WAIT};
            STEP_EMIT: uw = '{take_req: 1'b0, emit: 1'b1,
                              cond: JC_WHILE_MORE, target: STEP_EMIT};
        endcase
        return uw;
    endfunction

endpackage

@@ rtl/bud_seq.sv @@
module bud_seq #(
    parameter int COUNT_WIDTH = bud_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bud_pkg::WORD_BITS-1:0] word,
    input  logic [bud_pkg::BPV_W-1:0]     bits_per_value,
    input  logic [bud_pkg::ELEM_W-1:0]    element_count,
    input  logic                          adv,
    output bud_pkg::issue_t               issue
);

    localparam int EXT_W = (COUNT_WIDTH > bud_pkg::ELEM_W) ? COUNT_WIDTH : bud_pkg::ELEM_W;

    bud_pkg::step_t                 step_reg, step_next;
    logic [bud_pkg::BUF_W-1:0]      buf_reg, buf_next;
    logic [bud_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [bud_pkg::RES_W-1:0]      n_reg, n_next;
    logic [COUNT_WIDTH-1:0]         codes_reg, codes_next;

    bud_pkg::uword_t                uw;
    logic [EXT_W-1:0]               elem_ext;
    logic [COUNT_WIDTH-1:0]         total;
    logic [bud_pkg::CNT_W-1:0]      width;
    logic                           active;
    logic                           load;
    logic                           fire;
    logic                           jump;
    logic [bud_pkg::BUF_W-1:0]      shifted;
    logic [bud_pkg::CODE_W:0]       mask_wide;
    logic [bud_pkg::CODE_W-1:0]     code;
    logic [bud_pkg::CNT_W-1:0]      cnt_after;
    logic [COUNT_WIDTH-1:0]         codes_after;
    logic                           hit_total;
    logic                           final_code;

    // control word for the current step
    assign uw = bud_pkg::ucode_rom(step_reg);

    // stream length at the counter width
    assign elem_ext = EXT_W'(element_count);
    assign total    = elem_ext[COUNT_WIDTH-1:0];

    // effective code width, clamped to 1..16
    always_comb
    begin
        if (bits_per_value == '0)
            width = bud_pkg::CNT_W'(1);
        else if (bits_per_value > bud_pkg::BPV_W'(bud_pkg::CODE_W))
            width = bud_pkg::CNT_W'(bud_pkg::CODE_W);
        else
            width = bits_per_value;
    end

    // request side
    assign in_ready = uw.take_req;
    assign active   = codes_reg < total;
    assign load     = uw.take_req & in_valid & active;
    assign fire     = uw.emit & adv;

    // code extraction from the top of the valid bits
    assign cnt_after   = cnt_reg - width;
    assign shifted     = buf_reg >> cnt_after;
    assign mask_wide   = (bud_pkg::CODE_W+1)'(1) << width;
    assign code        = shifted[bud_pkg::CODE_W-1:0]
                         & bud_pkg::CODE_W'(mask_wide - (bud_pkg::CODE_W+1)'(1));
    assign codes_after = codes_reg + COUNT_WIDTH'(1);
    assign hit_total   = codes_after == total;
    assign final_code  = (cnt_after < width) || hit_total || (n_reg == '1);

    // code offered to the dequantiser
    assign issue = '{valid: uw.emit, code: code, last: final_code, done: hit_total};

    // jump condition
    always_comb
    begin
        unique case (uw.cond)
            bud_pkg::JC_UNLESS_LOAD: jump = !load;
            bud_pkg::JC_WHILE_MORE:  jump = !fire || !final_code;
        endcase
    end

    // next step
    always_comb
    begin
        if (jump)
            step_next = uw.target;
        else
            step_next = bud_pkg::step_t'(step_reg + bud_pkg::STEP_W'(1));
    end

    // datapath next values
    always_comb
    begin
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        codes_next = codes_reg;
        if (load)
        begin
            buf_next = {buf_reg[bud_pkg::BUF_W-bud_pkg::WORD_BITS-1:0], word};
            cnt_next = cnt_reg + bud_pkg::CNT_W'(bud_pkg::WORD_BITS);
            n_next   = '0;
        end
        else if (fire)
        begin
            cnt_next   = cnt_after;
            codes_next = codes_after;
            n_next     = n_reg + bud_pkg::RES_W'(1);
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= bud_pkg::STEP_WAIT;
            buf_reg   <= '0;
            cnt_reg   <= '0;
            n_reg     <= '0;
            codes_reg <= '0;
        end
        else
        begin
            step_reg  <= step_next;
            buf_reg   <= buf_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            codes_reg <= codes_next;
        end
    end

endmodule

@@ rtl/bit_unpack_dequantizer.sv @@
// path: once a word is taken the sequencer enters its emit step; each code then passes s1, s2 and the output register
// throughput: one code per cycle within a word while the output is not stalled; a word completes n codes, n in 1..16
// the pace is set by the microprogram: one wait step per word, one emit step per code; no word is taken while emitting
// words arriving after the stream is done are taken and yield nothing
// reset (rst_n, asynchronous, active low) clears the bit buffer, counts and pipeline valids
// and loads the register defaults: width 8, count 0, minimum 0, step 1.0
module bit_unpack_dequantizer #(
    parameter int COUNT_WIDTH = bud_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [bud_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bud_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [bud_pkg::WORD_BITS-1:0]         word,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [bud_pkg::CODE_W-1:0]            code,
    output logic signed [bud_pkg::VALUE_W-1:0]    value,
    output logic                                  last,
    output logic                                  done_res
);

    logic [bud_pkg::BPV_W-1:0]     bpv_reg;
    logic [bud_pkg::ELEM_W-1:0]    elem_reg;
    logic [bud_pkg::MIN_W-1:0]     min_reg;
    logic [bud_pkg::BUCKET_W-1:0]  bucket_reg;

    bud_pkg::issue_t               issue;
    logic                          adv;

    logic                          s1_valid_reg;
    logic [bud_pkg::CODE_W-1:0]    s1_code_reg;
    logic                          s1_last_reg;
    logic                          s1_done_reg;

    logic                          s2_valid_reg;
    logic [bud_pkg::CODE_W-1:0]    s2_code_reg;
    logic                          s2_last_reg;
    logic                          s2_done_reg;
    logic [bud_pkg::PROD_W-1:0]    prod_reg;
    logic [bud_pkg::PROD_W-1:0]    prod_next;

    logic                          out_valid_reg;
    logic [bud_pkg::CODE_W-1:0]    out_code_reg;
    logic                          out_last_reg;
    logic                          out_done_reg;
    logic [bud_pkg::VALUE_W-1:0]   value_reg;
    logic [bud_pkg::VALUE_W-1:0]   value_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpv_reg    <= bud_pkg::BPV_RST;
            elem_reg   <= bud_pkg::ELEM_RST;
            min_reg    <= bud_pkg::MIN_RST;
            bucket_reg <= bud_pkg::BUCKET_RST;
        end
        else if (cfg_we)
        begin
            unique case (bud_pkg::cfg_reg_t'(cfg_index))
                bud_pkg::REG_BITS_PER_VALUE: bpv_reg    <= cfg_data[bud_pkg::BPV_W-1:0];
                bud_pkg::REG_ELEMENT_COUNT:  elem_reg   <= cfg_data[bud_pkg::ELEM_W-1:0];
                bud_pkg::REG_MIN_VALUE:      min_reg    <= cfg_data[bud_pkg::MIN_W-1:0];
                bud_pkg::REG_BUCKET_SIZE:    bucket_reg <= cfg_data[bud_pkg::BUCKET_W-1:0];
            endcase
        end
    end

    // unpacker sequencer
    bud_seq #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .word           (word),
        .bits_per_value (bpv_reg),
        .element_count  (elem_reg),
        .adv            (adv),
        .issue          (issue)
    );

    // the whole pipeline moves when the output register is free or being drained
    assign adv = !out_valid_reg || out_ready;

    // multiply, then add the minimum and half a step
    assign prod_next  = bud_pkg::PROD_W'(s1_code_reg) * bud_pkg::PROD_W'(bucket_reg);
    assign value_next = bud_pkg::VALUE_W'(prod_reg)
                        + {{(bud_pkg::VALUE_W-bud_pkg::MIN_W){min_reg[bud_pkg::MIN_W-1]}},
                           min_reg}
                        + bud_pkg::VALUE_W'(bucket_reg >> 1);

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= issue.valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_code_reg  <= issue.code;
            s1_last_reg  <= issue.last;
            s1_done_reg  <= issue.done;
            s2_code_reg  <= s1_code_reg;
            s2_last_reg  <= s1_last_reg;
            s2_done_reg  <= s1_done_reg;
            prod_reg     <= prod_next;
            out_code_reg <= s2_code_reg;
            out_last_reg <= s2_last_reg;
            out_done_reg <= s2_done_reg;
            value_reg    <= value_next;
        end
    end

    // result ports
    assign out_valid = out_valid_reg;
    assign code      = out_code_reg;
    assign value     = value_reg;
    assign last      = out_last_reg;
    assign done_res  = out_done_reg;

endmodule

@@ rtl/bud_checker.sv @@
`include "bit_unpack_dequantizer_defines.svh"

module bud_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [bud_pkg::CODE_W-1:0]         code,
    input  logic signed [bud_pkg::VALUE_W-1:0] value,
    input  logic                               last,
    input  logic                               done_res
);

    // a stalled result stays offered
    `BUD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // a stalled result keeps its payload
    `BUD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(code) && $stable(value) && $stable(last) && $stable(done_res), "result changed while stalled")

    // the final code of the stream also closes its word
    `BUD_ASSERT_NOW(a_done_last, out_valid && done_res, last, "stream end without word end")

endmodule

bind bit_unpack_dequantizer bud_checker u_bud_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code      (code),
    .value     (value),
    .last      (last),
    .done_res  (done_res)
);

@@ tb/sv/bud_stream_checker.sv @@
module bud_stream_checker
    import bud_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [WORD_BITS-1:0]       word,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [CODE_W-1:0]          code,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic                       last,
    input  logic                       done_res,
    output int                         fail_count,
    output int                         codes_outstanding,
    output logic [COUNT_WIDTH_DEF-1:0] codes_done
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               done;
    } code_result_t;

    code_result_t expected_codes[$];

    // shadow copy of the registers
    logic [BPV_W-1:0]    width_reg;
    logic [ELEM_W-1:0]   count_reg;
    logic [MIN_W-1:0]    min_reg;
    logic [BUCKET_W-1:0] bucket_reg;

    // shadow copy of the unpacker state
    logic [BUF_W-1:0]           held_bits;
    logic [CNT_W-1:0]           held_count;
    logic [COUNT_WIDTH_DEF-1:0] emitted;

    int fails;

    // cut one word into codes and queue the dequantised results it completes
    task automatic unpack_word(input logic [WORD_BITS-1:0] w);
        int                 b;
        int                 n;
        logic [CODE_W-1:0]  c;
        logic [63:0]        sum;
        code_result_t       r;
        b = (width_reg == 0) ? 1 : ((width_reg > 16) ? 16 : int'(width_reg));
        n = 0;
        if (emitted >= count_reg)
            return;
        held_bits  = {held_bits[BUF_W-WORD_BITS-1:0], w};
        held_count = held_count + CNT_W'(WORD_BITS);
        while (int'(held_count) >= b && emitted < count_reg && n < MAX_RESULTS)
        begin
            c = CODE_W'((32'(held_bits) >> (int'(held_count) - b)) & ((32'd1 << b) - 32'd1));
            held_count = held_count - CNT_W'(b);
            emitted    = emitted + 1'b1;
            sum = 64'(c) * 64'(bucket_reg) + {{32{min_reg[MIN_W-1]}}, min_reg}
                + 64'(bucket_reg >> 1);
            r.code  = c;
            r.value = sum[VALUE_W-1:0];
            r.last  = 1'b0;
            r.done  = (emitted == count_reg);
            expected_codes.push_back(r);
            n++;
        end
        held_bits = held_bits & ((31'd1 << held_count) - 31'd1);
        if (n > 0)
            expected_codes[expected_codes.size()-1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        code_result_t want;
        if (!rst_n)
        begin
            width_reg  = BPV_RST;
            count_reg  = ELEM_RST;
            min_reg    = MIN_RST;
            bucket_reg = BUCKET_RST;
            held_bits  = '0;
            held_count = '0;
            emitted    = '0;
            fails      = 0;
            expected_codes.delete();
            fail_count        <= 0;
            codes_outstanding <= 0;
            codes_done        <= '0;
        end
        else
        begin
            // compare each result taken by the receiver with the oldest expectation
            if (out_valid && out_ready)
            begin
                if (expected_codes.size() == 0)
                begin
                    $error("unexpected result: code %h value %h", code, value);
                    fails++;
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (code !== want.code)
                    begin
                        $error("code: expected %h, got %h", want.code, code);
                        fails++;
                    end
                    if (value !== want.value)
                    begin
                        $error("value: expected %h, got %h", want.value, value);
                        fails++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, last);
                        fails++;
                    end
                    if (done_res !== want.done)
                    begin
                        $error("done_res: expected %b, got %b", want.done, done_res);
                        fails++;
                    end
                end
            end

            // a word request uses the registers as they stood before this edge
            if (in_valid && in_ready)
                unpack_word(word);

            // register writes
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_BITS_PER_VALUE: width_reg  = cfg_data[BPV_W-1:0];
                    REG_ELEMENT_COUNT:  count_reg  = cfg_data[ELEM_W-1:0];
                    REG_MIN_VALUE:      min_reg    = cfg_data[MIN_W-1:0];
                    REG_BUCKET_SIZE:    bucket_reg = cfg_data[BUCKET_W-1:0];
                    default: ;
                endcase
            end

            fail_count        <= fails;
            codes_outstanding <= expected_codes.size();
            codes_done        <= emitted;
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bud_pkg::*;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [WORD_BITS-1:0]       word;
    logic                       out_valid;
    logic                       out_ready;
    logic [CODE_W-1:0]          code;
    logic signed [VALUE_W-1:0]  value;
    logic                       last;
    logic                       done_res;

    int                         fail_count;
    int                         codes_outstanding;
    logic [COUNT_WIDTH_DEF-1:0] codes_done;

    int snd_idle_pct;
    int rcv_idle_pct;
    int hold_asks;

    bit_unpack_dequantizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .word      (word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .code      (code),
        .value     (value),
        .last      (last),
        .done_res  (done_res)
    );

    bud_stream_checker u_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .word              (word),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .code              (code),
        .value             (value),
        .last              (last),
        .done_res          (done_res),
        .fail_count        (fail_count),
        .codes_outstanding (codes_outstanding),
        .codes_done        (codes_done)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = 500;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // offer one word request, with an optional gap before it
    task automatic send_word(input logic [WORD_BITS-1:0] w);
        int gap;
        gap = 0;
        if ($urandom_range(99) < snd_idle_pct)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        word     <= w;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
    endtask

    // stop offering and let every expected result drain, then let the pipe settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (codes_outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // write enable is left high; cfg_end lowers it after a group of writes
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    task automatic cfg_end();
        cfg_we <= 1'b0;
    endtask

    // stimulus and verdict
    initial
    begin
        int                   raw_w;
        int                   eff_w;
        int                   nwords;
        int                   sel;
        int                   items;
        bit                   hold_done;
        logic [ELEM_W-1:0]    count_val;
        logic [BUCKET_W-1:0]  bucket_val;
        logic [MIN_W-1:0]     min_val;
        logic [WORD_BITS-1:0] w;

        cfg_we       = 1'b0;
        cfg_index    = REG_BITS_PER_VALUE;
        cfg_data     = '0;
        in_valid     = 1'b0;
        word         = '0;
        rst_n        = 1'b0;
        snd_idle_pct = 28;
        rcv_idle_pct = 78;
        hold_asks    = 0;
        items        = 0;
        hold_done    = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stream after reset: words are dropped
        send_word(16'hFFFF);
        send_word(16'h0000);
        wait_idle();

        // full-width codes, largest step, largest minimum; extra word after the end
        write_reg(REG_BITS_PER_VALUE, 32'd16);
        write_reg(REG_ELEMENT_COUNT, 32'd4);
        write_reg(REG_MIN_VALUE, 32'h7FFF_FFFF);
        write_reg(REG_BUCKET_SIZE, 32'h00FF_FFFF);
        cfg_end();
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_word(16'h8000);
        send_word(16'h0001);
        send_word(16'h1234);
        wait_idle();

        // count lowered below what was already produced
        write_reg(REG_ELEMENT_COUNT, 32'd2);
        cfg_end();
        send_word(16'hA5A5);
        wait_idle();

        // zero width acts as one bit, zero step, most negative minimum, ends mid-word
        write_reg(REG_BITS_PER_VALUE, 32'd0);
        write_reg(REG_ELEMENT_COUNT, 32'(codes_done) + 32'd20);
        write_reg(REG_MIN_VALUE, 32'h8000_0000);
        write_reg(REG_BUCKET_SIZE, 32'd0);
        cfg_end();
        send_word(16'hA5A5);
        send_word(16'h5A5A);
        send_word(16'hFFFF);
        wait_idle();

        // width beyond sixteen acts as sixteen; junk above the field
        write_reg(REG_BITS_PER_VALUE, 32'hFFFF_FFF1);
        write_reg(REG_ELEMENT_COUNT, 32'(codes_done) + 32'd40);
        write_reg(REG_MIN_VALUE, 32'd0);
        write_reg(REG_BUCKET_SIZE, 32'd1);
        cfg_end();
        send_word(16'h0001);
        send_word(16'hFFFE);
        wait_idle();

        // odd width, codes straddle word boundaries
        write_reg(REG_BITS_PER_VALUE, 32'd5);
        cfg_end();
        repeat (3) send_word(16'($urandom));
        wait_idle();

        // width 15 leaves bits over, then one-bit codes hit the per-word cap
        write_reg(REG_BITS_PER_VALUE, 32'd15);
        cfg_end();
        repeat (3) send_word(16'($urandom));
        wait_idle();
        write_reg(REG_BITS_PER_VALUE, 32'd1);
        cfg_end();
        send_word(16'($urandom));
        send_word(16'($urandom));
        wait_idle();

        // random streams in phases
        while (items < 350)
        begin
            if (items < 120)
            begin
                snd_idle_pct = 28;
                rcv_idle_pct = 78;
            end
            else if (items < 240)
            begin
                snd_idle_pct = 78;
                rcv_idle_pct = 28;
            end
            else
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end

            if ($urandom_range(7) == 0)
                raw_w = ($urandom_range(1) == 0) ? 0 : $urandom_range(17, 31);
            else
                raw_w = $urandom_range(1, 16);
            nwords = $urandom_range(2, 12);
            sel    = $urandom_range(15);

            // long receiver hold-off while one-bit codes keep coming
            if (items >= 240 && !hold_done)
            begin
                raw_w     = 1;
                nwords    = 12;
                sel       = 2;
                hold_done = 1'b1;
                hold_asks <= hold_asks + 1;
            end

            eff_w = (raw_w == 0) ? 1 : ((raw_w > 16) ? 16 : raw_w);
            if (sel == 0)
                count_val = '1;
            else if (sel == 1)
                count_val = codes_done;
            else
                count_val = codes_done + ELEM_W'(nwords * 16 / eff_w);

            write_reg(REG_BITS_PER_VALUE, {27'($urandom), 5'(raw_w)});
            write_reg(REG_ELEMENT_COUNT, {8'($urandom), count_val});
            if ($urandom_range(1) == 0)
            begin
                case ($urandom_range(7))
                    0:       min_val = 32'h8000_0000;
                    1:       min_val = 32'h7FFF_FFFF;
                    default: min_val = $urandom;
                endcase
                write_reg(REG_MIN_VALUE, min_val);
            end
            if ($urandom_range(1) == 0)
            begin
                case ($urandom_range(7))
                    0:       bucket_val = '0;
                    1:       bucket_val = '1;
                    2:       bucket_val = BUCKET_W'(65536);
                    default: bucket_val = BUCKET_W'($urandom);
                endcase
                write_reg(REG_BUCKET_SIZE, {8'($urandom), bucket_val});
            end
            cfg_end();

            for (int i = 0; i < nwords; i++)
            begin
                case ($urandom_range(9))
                    0:       w = 16'h0000;
                    1:       w = 16'hFFFF;
                    default: w = 16'($urandom);
                endcase
                send_word(w);
                // sometimes hold the sender until every result is out
                if (i == nwords / 2 && $urandom_range(3) == 0)
                    wait_idle();
            end
            if (sel != 1)
                items += nwords;
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0 && codes_outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
